// ----- src/hng_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, reset values, register indexes and pipeline payload types
// for the height-map normal generator. No dependencies.
package hng_pkg;

  localparam int GRID_W       = 11;
  localparam int GAIN_W       = 24;
  localparam int HEIGHT_W     = 16;
  localparam int SAMPLE_W     = HEIGHT_W + 1;
  localparam int POS_W        = 10;
  localparam int NORM_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int DIFF_W       = 17;
  localparam int PROD_W       = 41;
  localparam int SLOPE_W      = 32;
  localparam int MAG_W        = SLOPE_W - 1;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int SQ_REM_W     = ROOT_W + 2;
  localparam int FRAC_W       = 14;
  localparam int Q_W          = FRAC_W + 1;
  localparam int DIV_W        = ROOT_W + FRAC_W;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 72;
  localparam int MAX_GRID_DEF = 1024;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd128;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd162560;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_SLOPE_GAIN = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] own_row;
    logic             own;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] sx;
    logic signed [SLOPE_W-1:0] sy;
    side_t                     side;
  } sq_item_t;

endpackage

// ----- src/hng_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, carrying the
// slopes and pixel position alongside. Depends on hng_pkg.
module hng_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hng_pkg::RAD_W-1:0]     in_rad,
  input  hng_pkg::sq_item_t             in_item,
  output logic                          out_valid,
  output logic [hng_pkg::ROOT_W-1:0]    out_root,
  output hng_pkg::sq_item_t             out_item
);
  import hng_pkg::*;

  localparam int N = ROOT_W;

  logic [RAD_W-1:0]    rad      [N];
  logic [RAD_W-1:0]    rad_src  [N];
  logic [RAD_W-1:0]    rad_next [N];
  logic [SQ_REM_W-1:0] rem      [N];
  logic [SQ_REM_W-1:0] rem_src  [N];
  logic [SQ_REM_W-1:0] rem_next [N];
  logic [ROOT_W-1:0]   root     [N];
  logic [ROOT_W-1:0]   root_src [N];
  logic [ROOT_W-1:0]   root_next[N];
  sq_item_t            item     [N];
  sq_item_t            item_src [N];
  logic [N-1:0]        vld;

  always_comb begin
    rad_src[0]  = in_rad;
    rem_src[0]  = '0;
    root_src[0] = '0;
    item_src[0] = in_item;
    for (int k = 1; k < N; k++) begin
      rad_src[k]  = rad[k-1];
      rem_src[k]  = rem[k-1];
      root_src[k] = root[k-1];
      item_src[k] = item[k-1];
    end
  end

  always_comb begin : step
    logic [SQ_REM_W+1:0] cand;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;
    for (int k = 0; k < N; k++) begin
      cand  = {rem_src[k], rad_src[k][RAD_W-1 -: 2]};
      trial = {{(SQ_REM_W - ROOT_W){1'b0}}, root_src[k], 2'b01};
      ge    = (cand >= trial);
      rem_next[k]  = ge ? SQ_REM_W'(cand - trial) : cand[SQ_REM_W-1:0];
      root_next[k] = {root_src[k][ROOT_W-2:0], ge};
      rad_next[k]  = {rad_src[k][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rad[k]  <= rad_next[k];
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        item[k] <= item_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  assign out_valid = vld[N-1];
  assign out_root  = root[N-1];
  assign out_item  = item[N-1];

endmodule

// ----- src/hng_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage; the quotient is
// known to fit in Q_W bits. Depends on hng_pkg.
module hng_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hng_pkg::DIV_W-1:0]   num,
  input  logic [hng_pkg::ROOT_W-1:0]  den,
  output logic [hng_pkg::Q_W-1:0]     quo
);
  import hng_pkg::*;

  logic [DIV_W-1:0]  rem      [Q_W];
  logic [DIV_W-1:0]  rem_src  [Q_W];
  logic [DIV_W-1:0]  rem_next [Q_W];
  logic [ROOT_W-1:0] dq       [Q_W];
  logic [ROOT_W-1:0] dq_src   [Q_W];
  logic [Q_W-1:0]    q        [Q_W];
  logic [Q_W-1:0]    q_src    [Q_W];
  logic [Q_W-1:0]    q_next   [Q_W];

  always_comb begin
    rem_src[0] = num;
    dq_src[0]  = den;
    q_src[0]   = '0;
    for (int k = 1; k < Q_W; k++) begin
      rem_src[k] = rem[k-1];
      dq_src[k]  = dq[k-1];
      q_src[k]   = q[k-1];
    end
  end

  always_comb begin : step
    logic [DIV_W-1:0] trial;
    logic             ge;
    for (int k = 0; k < Q_W; k++) begin
      trial = {{(DIV_W - ROOT_W){1'b0}}, dq_src[k]} << (Q_W - 1 - k);
      ge    = (rem_src[k] >= trial);
      rem_next[k] = ge ? rem_src[k] - trial : rem_src[k];
      q_next[k]   = {q_src[k][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        rem[k] <= rem_next[k];
        dq[k]  <= dq_src[k];
        q[k]   <= q_next[k];
      end
    end
  end

  assign quo = q[Q_W-1];

endmodule

// ----- src/heightmap_normal_generator.sv -----
`timescale 1ns / 1ps
// Top level of the height-map normal generator: counters, line store, slope
// and normalize pipeline, output register. Depends on hng_pkg, hng_sqrt, hng_div.
//
// Usage: height samples enter in raster order on the s_axis request channel,
// one per cycle. For sample (x,y) the block returns the normal of pixel
// (x,y-1) on m_axis; samples of the final row also return their own zero
// border normal, with tlast on the last result of each sample. Row 0 gives
// no result. grid_size and slope_gain are written on the cfg port while idle.
// The result path runs through the 32-stage square root and the 15-stage
// dividers. Throughput: one sample per cycle while the output is taken;
// final-row samples hold the output for both of their results.
// The pipeline advances as one: when the output register holds a result the
// receiver does not take, every stage holds and s_axis_tready drops.
// Reset restores the register defaults, clears the counters and all valid
// bits; the line store is not cleared and is read only where written.
module heightmap_normal_generator #(
  parameter int MAX_GRID = hng_pkg::MAX_GRID_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hng_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // height[15:0]
  input  logic [0:0]                        s_axis_tuser,  // invalid[0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32], col[57:48], row[67:58]
  output logic [hng_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [0:0]                        m_axis_tuser,  // defined[0]
  output logic                              m_axis_tlast,
  input  logic                              cfg_write,
  input  logic [hng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hng_pkg::GAIN_W-1:0]        cfg_data
);
  import hng_pkg::*;

  localparam int CW      = $clog2(MAX_GRID);
  localparam int NW      = (CW + 1 > GRID_W) ? CW + 1 : GRID_W;
  localparam int OUT_PAD = OUT_DATA_W - 3 * NORM_W - 2 * POS_W;
  localparam logic [SLOPE_W:0] SLOPE_MAX = {2'b00, {(SLOPE_W - 1){1'b1}}};
  localparam logic [DIV_W-1:0] NY_NUM    = DIV_W'(65536) << FRAC_W;

  function automatic logic signed [SLOPE_W-1:0] slope_sat(
    input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [SLOPE_W:0]  m;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    rnd = mag + PROD_W'(128);
    m   = rnd[PROD_W-1:8];
    if (m > SLOPE_MAX) m = SLOPE_MAX;
    return p[PROD_W-1] ? -SLOPE_W'(m) : SLOPE_W'(m);
  endfunction

  // configuration
  logic [GRID_W-1:0] grid_size;
  logic [GAIN_W-1:0] slope_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= GRID_RESET;
      slope_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_SIZE:  grid_size  <= cfg_data[GRID_W-1:0];
        REG_SLOPE_GAIN: slope_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NW-1:0] gs, n;
  always_comb begin
    gs = NW'(grid_size);
    priority if (gs < NW'(3)) n = NW'(3);
    else if (gs > NW'(MAX_GRID)) n = NW'(MAX_GRID);
    else n = gs;
  end

  // position and handshake
  logic              adv, accept;
  logic [CW-1:0]     cc, rc, x, y, x_inc, x_dec;
  logic              restart, ph, row_end, frame_end;
  logic [SAMPLE_W-1:0] cur;

  assign restart   = (NW'(cc) >= n) || (NW'(rc) >= n);
  assign x         = restart ? '0 : cc;
  assign y         = restart ? '0 : rc;
  assign ph        = y[0];
  assign x_inc     = x + CW'(1);
  assign x_dec     = x - CW'(1);
  assign row_end   = (NW'(x) + NW'(1)) >= n;
  assign frame_end = (NW'(y) + NW'(1)) >= n;
  assign cur       = {s_axis_tuser[0], s_axis_tdata};
  assign accept    = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= '0;
      rc <= '0;
    end else if (accept) begin
      if (row_end) begin
        cc <= '0;
        rc <= frame_end ? '0 : y + CW'(1);
      end else begin
        cc <= x_inc;
      end
    end
  end

  // line store: one half per row parity
  logic [SAMPLE_W-1:0] line0 [MAX_GRID];
  logic [SAMPLE_W-1:0] line1 [MAX_GRID];
  logic [SAMPLE_W-1:0] rd0a, rd0b, rd1a, rd1b;

  always_ff @(posedge clk) begin
    if (accept && !ph) line0[x] <= cur;
    if (accept && ph)  line1[x] <= cur;
    if (adv) begin
      rd0a <= line0[ph ? x_inc : x];
      rd0b <= line0[x_dec];
      rd1a <= line1[ph ? x : x_inc];
      rd1b <= line1[x_dec];
    end
  end

  // stage 1
  logic                v1, ph1, zb1, own1;
  logic [POS_W-1:0]    col1, row1, orow1;
  logic [SAMPLE_W-1:0] cur1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= accept && (y != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph1   <= ph;
      zb1   <= (x == '0) || (NW'(x) >= n - NW'(1)) || (y == CW'(1));
      own1  <= (NW'(y) == n - NW'(1));
      col1  <= POS_W'(x);
      row1  <= POS_W'(y - CW'(1));
      orow1 <= POS_W'(y);
      cur1  <= cur;
    end
  end

  logic [SAMPLE_W-1:0] dn, rt, lf;
  assign dn = ph1 ? rd1a : rd0a;
  assign rt = ph1 ? rd0a : rd1a;
  assign lf = ph1 ? rd0b : rd1b;

  // stage 2: differences
  logic                     v2;
  logic signed [DIFF_W-1:0] dx2, dy2;
  side_t                    side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx2 <= signed'({1'b0, rt[HEIGHT_W-1:0]}) - signed'({1'b0, lf[HEIGHT_W-1:0]});
      dy2 <= signed'({1'b0, cur1[HEIGHT_W-1:0]}) - signed'({1'b0, dn[HEIGHT_W-1:0]});
      side2.col     <= col1;
      side2.row     <= row1;
      side2.own_row <= orow1;
      side2.own     <= own1;
      side2.zero    <= zb1 || lf[HEIGHT_W] || rt[HEIGHT_W] || dn[HEIGHT_W]
                       || cur1[HEIGHT_W];
    end
  end

  // stage 3: gain products
  logic                     v3;
  logic signed [PROD_W-1:0] px3, py3;
  logic signed [GAIN_W:0]   gain_s;
  side_t                    side3;

  assign gain_s = signed'({1'b0, slope_gain});

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px3   <= dx2 * gain_s;
      py3   <= dy2 * gain_s;
      side3 <= side2;
    end
  end

  // stage 4: round and saturate
  logic                      v4;
  logic signed [SLOPE_W-1:0] sx4, sy4;
  side_t                     side4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4   <= slope_sat(px3);
      sy4   <= slope_sat(py3);
      side4 <= side3;
    end
  end

  // stage 5: squares
  logic                      v5;
  logic [SQ_W-1:0]           sqx5, sqy5;
  logic signed [SLOPE_W-1:0] sx5, sy5;
  side_t                     side5;
  logic [SLOPE_W-1:0]        ax4, ay4;

  assign ax4 = sx4[SLOPE_W-1] ? SLOPE_W'(-sx4) : SLOPE_W'(sx4);
  assign ay4 = sy4[SLOPE_W-1] ? SLOPE_W'(-sy4) : SLOPE_W'(sy4);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx5  <= ax4[MAG_W-1:0] * ax4[MAG_W-1:0];
      sqy5  <= ay4[MAG_W-1:0] * ay4[MAG_W-1:0];
      sx5   <= sx4;
      sy5   <= sy4;
      side5 <= side4;
    end
  end

  // square root
  logic [RAD_W-1:0]  rad;
  sq_item_t          sq_in, sq_out;
  logic              sq_valid;
  logic [ROOT_W-1:0] root;

  assign rad = RAD_W'(sqx5) + RAD_W'(sqy5) + (RAD_W'(1) << 32);
  assign sq_in.sx   = sx5;
  assign sq_in.sy   = sy5;
  assign sq_in.side = side5;

  hng_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .in_rad    (rad),
    .in_item   (sq_in),
    .out_valid (sq_valid),
    .out_root  (root),
    .out_item  (sq_out)
  );

  // numerator setup
  logic               pv, pnegx, pnegz;
  logic [DIV_W-1:0]   pnx, pny, pnz;
  logic [ROOT_W-1:0]  proot;
  side_t              pside;
  logic [SLOPE_W-1:0] axr, azr;

  assign axr = sq_out.sx[SLOPE_W-1] ? SLOPE_W'(-sq_out.sx) : SLOPE_W'(sq_out.sx);
  assign azr = sq_out.sy[SLOPE_W-1] ? SLOPE_W'(-sq_out.sy) : SLOPE_W'(sq_out.sy);

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (adv) pv <= sq_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pnx   <= DIV_W'({axr[MAG_W-1:0], FRAC_W'(0)}) + DIV_W'(root >> 1);
      pny   <= NY_NUM + DIV_W'(root >> 1);
      pnz   <= DIV_W'({azr[MAG_W-1:0], FRAC_W'(0)}) + DIV_W'(root >> 1);
      proot <= root;
      pnegx <= !sq_out.sx[SLOPE_W-1];
      pnegz <= !sq_out.sy[SLOPE_W-1];
      pside <= sq_out.side;
    end
  end

  // dividers
  logic [Q_W-1:0] qx, qy, qz;

  hng_div u_div_x (.clk(clk), .en(adv), .num(pnx), .den(proot), .quo(qx));
  hng_div u_div_y (.clk(clk), .en(adv), .num(pny), .den(proot), .quo(qy));
  hng_div u_div_z (.clk(clk), .en(adv), .num(pnz), .den(proot), .quo(qz));

  logic [Q_W-1:0] dval;
  logic           dnegx [Q_W];
  logic           dnegz [Q_W];
  side_t          dside [Q_W];

  always_ff @(posedge clk) begin
    if (rst) dval <= '0;
    else if (adv) dval <= {dval[Q_W-2:0], pv};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnegx[0] <= pnegx;
      dnegz[0] <= pnegz;
      dside[0] <= pside;
      for (int k = 1; k < Q_W; k++) begin
        dnegx[k] <= dnegx[k-1];
        dnegz[k] <= dnegz[k-1];
        dside[k] <= dside[k-1];
      end
    end
  end

  logic [NORM_W-1:0] fx, fy, fz;
  side_t             fside;

  assign fside = dside[Q_W-1];
  assign fx = fside.zero ? '0
            : (dnegx[Q_W-1] ? NORM_W'(-{1'b0, qx}) : NORM_W'({1'b0, qx}));
  assign fy = fside.zero ? '0 : NORM_W'({1'b0, qy});
  assign fz = fside.zero ? '0
            : (dnegz[Q_W-1] ? NORM_W'(-{1'b0, qz}) : NORM_W'({1'b0, qz}));

  // output register
  logic              ob_full, phase, ob_last;
  logic [NORM_W-1:0] ob_nx, ob_ny, ob_nz;
  side_t             ob_side;

  assign ob_last = phase || !ob_side.own;
  assign adv     = !ob_full || (m_axis_tready && ob_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_full <= 1'b0;
      phase   <= 1'b0;
    end else if (adv) begin
      ob_full <= dval[Q_W-1];
      phase   <= 1'b0;
    end else if (m_axis_tready) begin
      phase   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_nx   <= fx;
      ob_ny   <= fy;
      ob_nz   <= fz;
      ob_side <= fside;
    end
  end

  assign m_axis_tvalid = ob_full;
  assign m_axis_tlast  = ob_last;
  assign m_axis_tuser  = phase ? 1'b0 : !ob_side.zero;
  assign m_axis_tdata  = phase
    ? {OUT_PAD'(0), ob_side.own_row, ob_side.col, {(3 * NORM_W){1'b0}}}
    : {OUT_PAD'(0), ob_side.row, ob_side.col, ob_nz, ob_ny, ob_nx};

endmodule
